// ===== sv/psd_pkg.sv =====
// Shared types, constants and lookup functions of the set 1 scan code decoder.
package psd_pkg;

  localparam logic [7:0] ScanPrefixE0 = 8'hE0;
  localparam logic [7:0] ScanPrefixE1 = 8'hE1;
  localparam logic [7:0] KeyPause     = 8'hFF;
  localparam logic [7:0] KeyNone      = 8'h00;

  // Key codes that drive the modifier word.
  localparam logic [7:0] KeyLShift = 8'h2A;
  localparam logic [7:0] KeyRShift = 8'h36;
  localparam logic [7:0] KeyLCtrl  = 8'h1D;
  localparam logic [7:0] KeyRCtrl  = 8'h9D;
  localparam logic [7:0] KeyLAlt   = 8'h38;
  localparam logic [7:0] KeyRAlt   = 8'hB8;
  localparam logic [7:0] KeyCaps   = 8'h3A;
  localparam logic [7:0] KeyNum    = 8'h45;
  localparam logic [7:0] KeyScroll = 8'h46;

  // Bit positions in the modifier word.
  localparam int unsigned ModLShift = 0;
  localparam int unsigned ModRShift = 1;
  localparam int unsigned ModLCtrl  = 2;
  localparam int unsigned ModRCtrl  = 3;
  localparam int unsigned ModLAlt   = 4;
  localparam int unsigned ModRAlt   = 5;
  localparam int unsigned ModCaps   = 6;
  localparam int unsigned ModNum    = 7;
  localparam int unsigned ModScroll = 8;

  localparam logic [8:0] ModReset = 9'h080;

  // One classified byte travelling from the front to the back.
  typedef struct packed {
    logic [7:0] key_code;
    logic [7:0] raw_byte;
    logic       pressed;
    logic       extended;
  } psd_item_t;

  function automatic logic plain_known(input logic [6:0] s);
    return ((s >= 7'h01) && (s <= 7'h53)) || (s == 7'h57) || (s == 7'h58);
  endfunction

  function automatic logic ext_known(input logic [6:0] s);
    logic k;
    unique case (s)
      7'h1C, 7'h1D, 7'h35, 7'h37, 7'h38,
      7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D,
      7'h4F, 7'h50, 7'h51, 7'h52, 7'h53: k = 1'b1;
      default:                           k = 1'b0;
    endcase
    return k;
  endfunction

  // US layout, no shift.
  function automatic logic [6:0] plain_char(input logic [6:0] s);
    logic [6:0] c;
    unique case (s)
      7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
      7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
      7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
      7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
      7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
      7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
      7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;  7'h1F: c = 7'h73;
      7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
      7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;  7'h27: c = 7'h3B;
      7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
      7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
      7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // US layout with shift: symbols differ, letters go upper case, the rest match.
  function automatic logic [6:0] shift_char(input logic [6:0] s);
    logic [6:0] c;
    logic [6:0] p;
    p = plain_char(s);
    unique case (s)
      7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
      7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
      7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
      7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;
      7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;  7'h33: c = 7'h3C;  7'h34: c = 7'h3E;
      7'h35: c = 7'h3F;
      default: begin
        if ((p >= 7'h61) && (p <= 7'h7A)) begin
          c = p - 7'h20;
        end else begin
          c = p;
        end
      end
    endcase
    return c;
  endfunction

endpackage

// ===== sv/psd_front.sv =====
// Front part: accepts scan bytes, tracks the E0/E1 prefixes and classifies keys.
module psd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           scan_byte_i,
  input  logic                 q_full_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output psd_pkg::psd_item_t   item_o
);

  logic       e0_q, e0_d;
  logic       e1_q, e1_d;
  logic       accept;
  logic       is_e0, is_e1;
  logic [6:0] s;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_e0      = (scan_byte_i == psd_pkg::ScanPrefixE0);
  assign is_e1      = (scan_byte_i == psd_pkg::ScanPrefixE1);
  assign s          = scan_byte_i[6:0];
  assign push_o     = accept && !is_e0 && !is_e1;

  always_comb begin
    item_o.raw_byte = scan_byte_i;
    item_o.pressed  = !scan_byte_i[7];
    item_o.extended = e0_q || e1_q;
    priority if (e0_q) begin
      item_o.key_code = psd_pkg::ext_known(s) ? {1'b1, s} : psd_pkg::KeyNone;
    end else if (e1_q) begin
      item_o.key_code = psd_pkg::KeyPause;
    end else begin
      item_o.key_code = psd_pkg::plain_known(s) ? {1'b0, s} : psd_pkg::KeyNone;
    end
  end

  // The E0 rule wins when both prefixes are pending; E1 then waits a byte more.
  always_comb begin
    e0_d = e0_q;
    e1_d = e1_q;
    if (accept) begin
      priority if (is_e0) begin
        e0_d = 1'b1;
      end else if (is_e1) begin
        e1_d = 1'b1;
      end else if (e0_q) begin
        e0_d = 1'b0;
      end else begin
        e1_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_q <= 1'b0;
      e1_q <= 1'b0;
    end else begin
      e0_q <= e0_d;
      e1_q <= e1_d;
    end
  end

endmodule

// ===== sv/psd_queue.sv =====
// Two-entry queue of classified items between the front and the back.
module psd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  psd_pkg::psd_item_t   item_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output psd_pkg::psd_item_t   item_o
);

  psd_pkg::psd_item_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/psd_back.sv =====
// Back part: updates the modifier word, translates to ASCII and holds the event.
module psd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  psd_pkg::psd_item_t   item_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [7:0]           key_code_o,
  output logic [7:0]           raw_byte_o,
  output logic                 pressed_o,
  output logic                 extended_o,
  output logic [8:0]           modifiers_o,
  output logic [6:0]           ascii_o,
  output logic [2:0]           leds_o,
  output logic                 leds_changed_o
);

  logic [8:0] mods_q, mods_d;
  logic       out_valid_q, out_valid_d;
  logic [8:0] hold, lock;
  logic       lock_press;
  logic [6:0] s, c_tab, c_case, ascii_d;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign s     = item_i.raw_byte[6:0];

  always_comb begin
    hold = '0;
    lock = '0;
    unique case (item_i.key_code)
      psd_pkg::KeyLShift: hold[psd_pkg::ModLShift] = 1'b1;
      psd_pkg::KeyRShift: hold[psd_pkg::ModRShift] = 1'b1;
      psd_pkg::KeyLCtrl:  hold[psd_pkg::ModLCtrl]  = 1'b1;
      psd_pkg::KeyRCtrl:  hold[psd_pkg::ModRCtrl]  = 1'b1;
      psd_pkg::KeyLAlt:   hold[psd_pkg::ModLAlt]   = 1'b1;
      psd_pkg::KeyRAlt:   hold[psd_pkg::ModRAlt]   = 1'b1;
      psd_pkg::KeyCaps:   lock[psd_pkg::ModCaps]   = 1'b1;
      psd_pkg::KeyNum:    lock[psd_pkg::ModNum]    = 1'b1;
      psd_pkg::KeyScroll: lock[psd_pkg::ModScroll] = 1'b1;
      default: ;
    endcase
  end

  assign lock_press = (lock != '0) && item_i.pressed;

  always_comb begin
    mods_d = item_i.pressed ? (mods_q | hold) : (mods_q & ~hold);
    if (lock_press) begin
      mods_d = mods_d ^ lock;
    end
  end

  // Caps lock swaps the case of letters only, after the shift choice.
  always_comb begin
    c_tab  = (mods_d[psd_pkg::ModLShift] || mods_d[psd_pkg::ModRShift]) ?
             psd_pkg::shift_char(s) : psd_pkg::plain_char(s);
    c_case = c_tab;
    if (mods_d[psd_pkg::ModCaps]) begin
      if ((c_tab >= 7'h61) && (c_tab <= 7'h7A)) begin
        c_case = c_tab - 7'h20;
      end else if ((c_tab >= 7'h41) && (c_tab <= 7'h5A)) begin
        c_case = c_tab + 7'h20;
      end
    end
    ascii_d = (item_i.pressed && !item_i.extended) ? c_case : 7'h00;
  end

  assign out_valid_d = pop_o ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q      <= psd_pkg::ModReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        mods_q <= mods_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      key_code_o     <= item_i.key_code;
      raw_byte_o     <= item_i.raw_byte;
      pressed_o      <= item_i.pressed;
      extended_o     <= item_i.extended;
      modifiers_o    <= mods_d;
      ascii_o        <= ascii_d;
      leds_o         <= {mods_d[psd_pkg::ModCaps], mods_d[psd_pkg::ModNum],
                         mods_d[psd_pkg::ModScroll]};
      leds_changed_o <= lock_press;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/ps2_set1_scancode_decoder_core.sv =====
// Top level of the PS/2 scan code set 1 decoder.
//
// Input channel: one raw set 1 byte per transfer on scan_byte_i, qualified by
// in_valid_i and held off by in_stall_o. Output channel: one key event per
// transfer, qualified by out_valid_o and held off by out_stall_i.
// The prefix bytes E0 and E1 are consumed without producing an event; every
// other byte produces exactly one event, in order.
// An accepted byte reaches the output through the queue and then the back's
// output register: the front classifies the byte into a two-entry queue, and
// the back updates the modifier word and registers the event. While the
// receiver does not stall, the block sustains one byte per cycle; the queue
// stalls the input when both of its entries are occupied.
// When the receiver stalls, the held event stays put, the back stops draining
// the queue, and the input keeps taking bytes until the queue fills up.
// Reset clears both prefix flags, empties the queue and the output register,
// and sets the modifier word to num lock on (on leds_o from the first event).
// The LED word is always the lock bits of the modifier word, so leds_o and
// modifiers_o never disagree.
module ps2_set1_scancode_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] key_code_o,
  output logic [7:0] raw_byte_o,
  output logic       pressed_o,
  output logic       extended_o,
  output logic [8:0] modifiers_o,
  output logic [6:0] ascii_o,
  output logic [2:0] leds_o,
  output logic       leds_changed_o
);

  psd_pkg::psd_item_t front_item, back_item;
  logic push, pop, q_full, q_valid;

  // Prefix tracking and key classification.
  psd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .scan_byte_i (scan_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (front_item)
  );

  // Decouples the two halves so that each can stall on its own.
  psd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  // Modifier state, ASCII translation and the output register.
  psd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .item_i         (back_item),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .key_code_o     (key_code_o),
    .raw_byte_o     (raw_byte_o),
    .pressed_o      (pressed_o),
    .extended_o     (extended_o),
    .modifiers_o    (modifiers_o),
    .ascii_o        (ascii_o),
    .leds_o         (leds_o),
    .leds_changed_o (leds_changed_o)
  );

  // The LED word mirrors the lock bits of the modifier word.
  a_leds_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (leds_o == {modifiers_o[psd_pkg::ModCaps], modifiers_o[psd_pkg::ModNum],
                                modifiers_o[psd_pkg::ModScroll]}))
    else $error("LED word disagrees with lock bits");

  // Only a lock key press can change the LEDs.
  a_leds_on_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && leds_changed_o) |-> (pressed_o && !extended_o))
    else $error("LED change on a release or extended event");

  // A character comes only from a plain key press.
  a_ascii_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (ascii_o != 7'h00)) |-> (pressed_o && !extended_o))
    else $error("ASCII on a release or after a prefix");

  // Prefix bytes never reach the queue.
  a_no_prefix_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((front_item.raw_byte != psd_pkg::ScanPrefixE0) &&
              (front_item.raw_byte != psd_pkg::ScanPrefixE1)))
    else $error("Prefix byte was queued as an event");

endmodule
